/* src/trajectory_smoothing_correction_top_macros.svh */
// ----------------------------------------------------------------------------
// Trajectory smoothing correction: assertion macros
// Implication checks on the rising clock edge, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef TRAJECTORY_SMOOTHING_CORRECTION_TOP_MACROS_SVH
`define TRAJECTORY_SMOOTHING_CORRECTION_TOP_MACROS_SVH

`ifndef SYNTH
`define TSC_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
        else $error("tsc assertion failed: same cycle");
`define TSC_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
        else $error("tsc assertion failed: next cycle");
`else
`define TSC_ASSERT_IMP(lbl, clk, rst_n, pre, post)
`define TSC_ASSERT_NXT(lbl, clk, rst_n, pre, post)
`endif

`endif

/* src/tsc_pkg.sv */
// ----------------------------------------------------------------------------
// Trajectory smoothing correction: package
// Word types, field widths and shared constants.
// ----------------------------------------------------------------------------
package tsc_pkg;

    localparam int NCH         = 3;
    localparam int SHIFT_W     = 20;
    localparam int TURN_W      = 16;
    localparam int FIX_W       = 24;
    localparam int FIX_TURN_W  = 20;
    localparam int PATH_W      = 32;
    localparam int PATH_TURN_W = 28;
    localparam int SUM_W       = 38;
    localparam int WIDE_W      = SUM_W + 1;
    localparam int CNT_W       = 6;
    localparam int RAD_W       = 5;
    localparam int RAD_CAP     = 31;
    localparam int APB_AW      = 3;
    localparam int APB_DW      = 32;

    localparam logic [RAD_W-1:0]    RAD_RESET  = 5'd20;
    localparam logic [APB_AW-3:0]   REG_RADIUS = '0;

    localparam int PATH_BITS [NCH] = '{PATH_W, PATH_W, PATH_TURN_W};
    localparam int OUT_BITS  [NCH] = '{FIX_W, FIX_W, FIX_TURN_W};

    typedef struct packed {
        logic signed [SHIFT_W-1:0] shift_x;
        logic signed [SHIFT_W-1:0] shift_y;
        logic signed [TURN_W-1:0]  turn;
        logic                      final_frame;
    } t_motion;

    typedef struct packed {
        logic signed [FIX_W-1:0]      fixed_x;
        logic signed [FIX_W-1:0]      fixed_y;
        logic signed [FIX_TURN_W-1:0] fixed_turn;
        logic                         end_of_run;
    } t_fix;

    typedef struct packed {
        logic signed [PATH_W-1:0]      x;
        logic signed [PATH_W-1:0]      y;
        logic signed [PATH_TURN_W-1:0] turn;
    } t_path;

    typedef struct packed {
        logic [NCH-1:0][SUM_W-1:0] num;
        logic [CNT_W-1:0]          den;
    } t_div_req;

    typedef struct packed {
        logic [NCH-1:0][SUM_W-1:0] quo;
    } t_div_res;

endpackage

/* src/tsc_div.sv */
// ----------------------------------------------------------------------------
// Trajectory smoothing correction: window divider
// Three restoring divider lanes sharing one step counter, one quotient bit
// per cycle, unsigned dividend over a small window count.
// ----------------------------------------------------------------------------
module tsc_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  tsc_pkg::t_div_req  i_req,
    output logic               o_done,
    output tsc_pkg::t_div_res  o_res
);

    localparam int SW     = tsc_pkg::SUM_W;
    localparam int CW     = tsc_pkg::CNT_W;
    localparam int NC     = tsc_pkg::NCH;
    localparam int STEP_W = $clog2(SW + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [CW-1:0]     r_den;
    logic [SW-1:0]     r_num [NC];
    logic [CW-1:0]     r_rem [NC];

    logic [CW:0]       trial [NC];
    logic              fit   [NC];
    logic [CW-1:0]     n_rem [NC];

    always_comb begin
        for (int ch = 0; ch < NC; ch++) begin
            trial[ch] = {r_rem[ch], r_num[ch][SW-1]};
            fit[ch]   = trial[ch] >= {1'b0, r_den};
            n_rem[ch] = fit[ch] ? CW'(trial[ch] - {1'b0, r_den}) : CW'(trial[ch]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(SW);
                r_den  <= i_req.den;
                for (int ch = 0; ch < NC; ch++) begin
                    r_num[ch] <= i_req.num[ch];
                    r_rem[ch] <= '0;
                end
            end else if (r_busy) begin
                for (int ch = 0; ch < NC; ch++) begin
                    r_num[ch] <= {r_num[ch][SW-2:0], fit[ch]};
                    r_rem[ch] <= n_rem[ch];
                end
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;

    always_comb begin
        for (int ch = 0; ch < NC; ch++) begin
            o_res.quo[ch] = r_num[ch];
        end
    end

endmodule

/* src/trajectory_smoothing_correction_top.sv */
// ----------------------------------------------------------------------------
// Trajectory smoothing correction: top level
// Accumulates frame motions into a camera path held in a ring memory, keeps
// running window sums and emits the path correction of a centered moving
// average, truncated at the ends of each run.
//
//  channel  dir  handshake                word
//  in       in   i_in_valid / o_in_stall  t_motion
//  out      out  o_out_valid / i_out_stall t_fix
//  cfg      in   psel/penable/pwrite      smoothing_radius at byte 0
//
// An arrival with no result passes through the ring write and the window
// update. A result passes through two ring reads, the divider (38 quotient
// steps per lane) and the output step; a final frame drains the pending
// results one after another.
// Reset is synchronous; the ring needs no clearing pass.
// o_in_stall is high outside the idle state; a stalled output holds the
// result step.
// ----------------------------------------------------------------------------
`include "trajectory_smoothing_correction_top_macros.svh"

module trajectory_smoothing_correction_top #(
    parameter int MAX_RADIUS = 31,
    parameter int RING_DEPTH = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  tsc_pkg::t_motion              i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output tsc_pkg::t_fix                 o_out_word,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tsc_pkg::APB_AW-1:0]    paddr,
    input  logic [tsc_pkg::APB_DW-1:0]    pwdata,
    output logic [tsc_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    localparam int NC    = tsc_pkg::NCH;
    localparam int RW    = tsc_pkg::RAD_W;
    localparam int SW    = tsc_pkg::SUM_W;
    localparam int WW    = tsc_pkg::WIDE_W;
    localparam int PW    = tsc_pkg::PATH_W;
    localparam int CW    = tsc_pkg::CNT_W;
    localparam int AW    = tsc_pkg::APB_AW;
    localparam int DW    = tsc_pkg::APB_DW;
    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int LIM_A = (MAX_RADIUS < (RING_DEPTH - 2) / 2) ? MAX_RADIUS
                                                               : (RING_DEPTH - 2) / 2;
    localparam int LIM_B = (LIM_A < tsc_pkg::RAD_CAP) ? LIM_A : tsc_pkg::RAD_CAP;

    localparam logic [RW-1:0]    RAD_LIM  = RW'(LIM_B);
    localparam logic [PTR_W:0]   DEPTH_X  = (PTR_W + 1)'(RING_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACC,
        S_RD_PREV,
        S_RD_DROP,
        S_LOAD,
        S_DIV,
        S_OUT
    } t_state;

    function automatic logic signed [WW-1:0] sat_to(input logic signed [WW-1:0] v,
                                                    input int bits);
        logic signed [WW-1:0] hi;
        logic signed [WW-1:0] lo;
        hi = $signed((WW'(1) << (bits - 1)) - WW'(1));
        lo = ~hi;
        sat_to = (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_back(input logic [PTR_W-1:0] pos,
                                                  input logic [RW-1:0] x);
        logic [PTR_W:0] t;
        t = {1'b0, pos} + DEPTH_X - (PTR_W + 1)'(x);
        ptr_back = (t >= DEPTH_X) ? PTR_W'(t - DEPTH_X) : PTR_W'(t);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] pos);
        ptr_next = (pos == PTR_LAST) ? '0 : pos + 1'b1;
    endfunction

    tsc_pkg::t_path r_ring [RING_DEPTH];
    tsc_pkg::t_path r_rdata;

    t_state                  r_state;
    logic [RW-1:0]           r_radius;
    logic [31:0]             r_taken;
    logic [31:0]             r_given;
    logic [PTR_W-1:0]        r_head;
    logic [PTR_W-1:0]        r_out_pos;
    logic                    r_wrapped;
    logic                    r_final;
    logic signed [SW-1:0]    r_wsum [NC];
    logic signed [PW-1:0]    r_cur  [NC];
    logic signed [PW-1:0]    r_last [NC];
    logic signed [PW-1:0]    r_prev [NC];
    logic signed [PW-1:0]    r_drop [NC];
    logic [SW-1:0]           r_mag  [NC];
    logic                    r_neg  [NC];
    logic signed [SW-1:0]    r_avg  [NC];
    logic [CW-1:0]           r_cnt;
    logic                    r_out_valid;
    tsc_pkg::t_fix           r_out_word;

    logic                    in_take;
    logic                    cfg_wr;
    logic                    out_free;
    logic                    last_word;
    logic                    run_clear;
    logic                    has_prev_in;
    logic                    has_prev_out;
    logic                    drop_ok;
    logic [RW-1:0]           eff_r;
    logic [31:0]             pending;
    logic [31:0]             k_back;
    logic [RW-1:0]           ahead;
    logic [RW-1:0]           before_cnt;
    logic [CW-1:0]           n_cnt;
    logic [PTR_W-1:0]        rd_addr;
    logic signed [WW-1:0]    in_d   [NC];
    logic signed [WW-1:0]    n_path [NC];
    logic signed [PW-1:0]    rd_path [NC];
    logic signed [WW-1:0]    n_fix  [NC];
    tsc_pkg::t_div_req       div_req;
    tsc_pkg::t_div_res       div_res;
    logic                    div_done;

    assign in_take      = i_in_valid && (r_state == S_IDLE);
    assign cfg_wr       = psel && penable && pwrite && (paddr[AW-1:2] == tsc_pkg::REG_RADIUS);
    assign out_free     = !r_out_valid || !i_out_stall;
    assign eff_r        = (r_radius > RAD_LIM) ? RAD_LIM : r_radius;
    assign pending      = r_taken - r_given;
    assign k_back       = pending - 32'd1;
    assign ahead        = (k_back < 32'(eff_r)) ? k_back[RW-1:0] : eff_r;
    assign before_cnt   = r_wrapped ? eff_r
                        : ((r_given < 32'(eff_r)) ? r_given[RW-1:0] : eff_r);
    assign n_cnt        = CW'(ahead) + CW'(before_cnt) + CW'(1);
    assign has_prev_in  = r_wrapped || (r_taken != 32'd0);
    assign has_prev_out = r_wrapped || (r_given != 32'd0);
    assign drop_ok      = r_wrapped || (r_given >= 32'(eff_r));
    assign last_word    = r_final && (pending == 32'd1);
    assign run_clear    = cfg_wr || ((r_state == S_OUT) && out_free && last_word);
    assign rd_addr      = (r_state == S_RD_PREV) ? ptr_back(r_out_pos, RW'(1))
                                                 : ptr_back(r_out_pos, eff_r);

    always_comb begin
        in_d[0]    = WW'($signed(i_in_word.shift_x));
        in_d[1]    = WW'($signed(i_in_word.shift_y));
        in_d[2]    = WW'($signed(i_in_word.turn));
        rd_path[0] = r_rdata.x;
        rd_path[1] = r_rdata.y;
        rd_path[2] = PW'($signed(r_rdata.turn));
        for (int ch = 0; ch < NC; ch++) begin
            n_path[ch] = sat_to((has_prev_in ? WW'(r_last[ch]) : WW'(0)) + in_d[ch],
                                tsc_pkg::PATH_BITS[ch]);
            n_fix[ch]  = sat_to(WW'(r_avg[ch]) - WW'(r_prev[ch]), tsc_pkg::OUT_BITS[ch]);
            div_req.num[ch] = r_mag[ch] + SW'(r_cnt >> 1);
        end
        div_req.den = r_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_ring[r_head] <= tsc_pkg::t_path'{
                x:    n_path[0][PW-1:0],
                y:    n_path[1][PW-1:0],
                turn: n_path[2][tsc_pkg::PATH_TURN_W-1:0]
            };
        end
        r_rdata <= r_ring[rd_addr];
    end

    tsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_state == S_LOAD),
        .i_req   (div_req),
        .o_done  (div_done),
        .o_res   (div_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_radius    <= tsc_pkg::RAD_RESET;
            r_taken     <= '0;
            r_given     <= '0;
            r_head      <= '0;
            r_out_pos   <= '0;
            r_wrapped   <= 1'b0;
            r_final     <= 1'b0;
            r_out_valid <= 1'b0;
            for (int ch = 0; ch < NC; ch++) begin
                r_wsum[ch] <= '0;
            end
        end else begin
            if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_wr) begin
                r_radius <= pwdata[RW-1:0];
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_take) begin
                        for (int ch = 0; ch < NC; ch++) begin
                            r_cur[ch] <= n_path[ch][PW-1:0];
                        end
                        r_final <= i_in_word.final_frame;
                        r_taken <= r_taken + 32'd1;
                        if (r_taken == '1) begin
                            r_wrapped <= 1'b1;
                        end
                        r_head  <= ptr_next(r_head);
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    for (int ch = 0; ch < NC; ch++) begin
                        r_wsum[ch] <= r_wsum[ch] + SW'(r_cur[ch]);
                        r_last[ch] <= r_cur[ch];
                    end
                    r_state <= (r_final || (pending > 32'(eff_r))) ? S_RD_PREV : S_IDLE;
                end
                S_RD_PREV: begin
                    r_state <= S_RD_DROP;
                end
                S_RD_DROP: begin
                    for (int ch = 0; ch < NC; ch++) begin
                        r_prev[ch] <= has_prev_out ? rd_path[ch] : PW'(0);
                        r_neg[ch]  <= r_wsum[ch][SW-1];
                        r_mag[ch]  <= r_wsum[ch][SW-1] ? SW'(-r_wsum[ch]) : SW'(r_wsum[ch]);
                    end
                    r_cnt   <= n_cnt;
                    r_state <= S_LOAD;
                end
                S_LOAD: begin
                    for (int ch = 0; ch < NC; ch++) begin
                        r_drop[ch] <= rd_path[ch];
                    end
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        for (int ch = 0; ch < NC; ch++) begin
                            r_avg[ch] <= r_neg[ch] ? -$signed(div_res.quo[ch])
                                                   : $signed(div_res.quo[ch]);
                        end
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid                <= 1'b1;
                        r_out_word.fixed_x         <= n_fix[0][tsc_pkg::FIX_W-1:0];
                        r_out_word.fixed_y         <= n_fix[1][tsc_pkg::FIX_W-1:0];
                        r_out_word.fixed_turn      <= n_fix[2][tsc_pkg::FIX_TURN_W-1:0];
                        r_out_word.end_of_run      <= last_word;
                        for (int ch = 0; ch < NC; ch++) begin
                            r_wsum[ch] <= r_wsum[ch] - (drop_ok ? SW'(r_drop[ch]) : SW'(0));
                        end
                        r_given   <= r_given + 32'd1;
                        r_out_pos <= ptr_next(r_out_pos);
                        r_state   <= (r_final && !last_word) ? S_RD_PREV : S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (run_clear) begin
                r_taken   <= '0;
                r_given   <= '0;
                r_head    <= '0;
                r_out_pos <= '0;
                r_wrapped <= 1'b0;
                for (int ch = 0; ch < NC; ch++) begin
                    r_wsum[ch] <= '0;
                end
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;
    assign pready      = 1'b1;
    assign prdata      = (paddr[AW-1:2] == tsc_pkg::REG_RADIUS) ? DW'(r_radius) : '0;

    `TSC_ASSERT_IMP(a_pending_bound, i_clk, i_rst_n, 1'b1, pending <= 32'd32)
    `TSC_ASSERT_IMP(a_div_done_in_wait, i_clk, i_rst_n, div_done, r_state == S_DIV)
    `TSC_ASSERT_NXT(a_word_from_out_step, i_clk, i_rst_n, (r_state != S_OUT) && !r_out_valid, !r_out_valid)

endmodule
